// ===== rtl/lmbs_pkg.sv =====
`default_nettype none

package lmbs_pkg;

  localparam int PLANES_DEF  = 4;
  localparam int ROWS_DEF    = 16;
  localparam int STRIP_COLS  = 192;
  localparam int ROW_BYTES   = 2 * STRIP_COLS + 6;
  localparam int STORE_DEPTH = 16 * STRIP_COLS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ROW_W       = 4;
  localparam int COL_W       = 9;
  localparam int X_W         = 6;
  localparam int Y_W         = 7;
  localparam int COLOR_W     = 16;
  localparam int BYTE_W      = 8;
  localparam int STYLE_W     = 2;
  localparam int PLANE_BITS  = 6;

  typedef enum logic {
    FUNC_DRAW = 1'b0,
    FUNC_SCAN = 1'b1
  } func_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
  } store_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/lmbs_ifs.sv =====
`default_nettype none

interface lmbs_cmd_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [lmbs_pkg::X_W-1:0]      pixel_x;
  logic [lmbs_pkg::Y_W-1:0]      pixel_y;
  logic [lmbs_pkg::COLOR_W-1:0]  pixel_color;

  modport source (output valid, func, pixel_x, pixel_y, pixel_color, input ready);
  modport sink (input valid, func, pixel_x, pixel_y, pixel_color, output ready);
endinterface

interface lmbs_stream_if;
  logic                         valid;
  logic                         ready;
  logic [lmbs_pkg::BYTE_W-1:0]  out_byte;
  logic                         frame_end;

  modport source (output valid, out_byte, frame_end, input ready);
  modport sink (input valid, out_byte, frame_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/lmbs_store.sv =====
`default_nettype none

module lmbs_store #(
  parameter int PLANES = lmbs_pkg::PLANES_DEF,
  localparam int DATA_W = lmbs_pkg::PLANE_BITS * PLANES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lmbs_pkg::store_ctl_t ctl,
  input  logic [DATA_W-1:0]    wr_data,
  output logic [DATA_W-1:0]    rd_data,
  output logic                 ready
);

  logic [DATA_W-1:0]           mem [lmbs_pkg::STORE_DEPTH];
  logic                        clearing;
  logic [lmbs_pkg::ADDR_W-1:0] clr_addr;

  // sweep zeros through the store after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == lmbs_pkg::ADDR_W'(lmbs_pkg::STORE_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[ctl.rd_addr];
    end
  end

  assign ready = !clearing;

endmodule

`default_nettype wire

// ===== rtl/led_matrix_bitplane_scanout.sv =====
// scan: the store is read when a tick is accepted; its byte is registered at the output in
// the busy state once the output register is free; a draw writes the store in the cycle after
// acceptance. A new request is not taken until the last is through (store read, then
// write-back or output load); a scan tick waits in the busy state while the sink holds the
// output register. Reset: synchronous, clears scan counters, style and output valid; then a
// clearing pass zeroes the pixel store with cmd.ready held low
`default_nettype none

module led_matrix_bitplane_scanout #(
  parameter int PLANES = lmbs_pkg::PLANES_DEF,
  parameter int ROWS   = lmbs_pkg::ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  lmbs_cmd_if.sink                      cmd,
  lmbs_stream_if.source                 stream,
  input  logic                          cfg_we,
  input  logic [lmbs_pkg::STYLE_W-1:0]  cfg_wdata
);

  localparam int DATA_W  = lmbs_pkg::PLANE_BITS * PLANES;
  localparam int PLANE_W = $clog2(PLANES + 1);
  localparam int ADDR_W  = lmbs_pkg::ADDR_W;
  localparam int COL_W   = lmbs_pkg::COL_W;
  localparam int ROW_W   = lmbs_pkg::ROW_W;

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } state_t;

  function automatic logic [7:0] ctrl_byte(input logic [ROW_W-1:0] row,
                                           input logic [2:0] k, input logic alt);
    logic [7:0] pat;
    if (alt) begin
      case (k)
        3'd0: pat = 8'd48;
        3'd1: pat = 8'd176;
        3'd2: pat = 8'd0;
        3'd3: pat = 8'd128;
        3'd4: pat = 8'd0;
        3'd5: pat = 8'd128;
        default: pat = 8'd0;
      endcase
    end else begin
      case (k)
        3'd0: pat = 8'd32;
        3'd1: pat = 8'd160;
        3'd2: pat = 8'd48;
        3'd3: pat = 8'd176;
        3'd4: pat = 8'd0;
        3'd5: pat = 8'd128;
        default: pat = 8'd0;
      endcase
    end
    return 8'({4'b0, row}) + pat;
  endfunction

  state_t                       state;
  logic [lmbs_pkg::STYLE_W-1:0] style;
  logic [PLANE_W-1:0]           scan_plane, scan_plane_next;
  logic [ROW_W-1:0]             scan_row, scan_row_next;
  logic [COL_W-1:0]             scan_column, scan_column_next;

  logic                         pend_draw;
  logic                         draw_en;
  logic                         draw_hi;
  logic [ADDR_W-1:0]            draw_addr;
  logic [PLANES-1:0][2:0]       draw_bits;
  logic                         scan_data_sel;
  logic                         scan_odd;
  logic [PLANE_W-1:0]           scan_sel_plane;
  logic [7:0]                   scan_byte;
  logic                         scan_end;

  logic                         out_valid;
  logic [7:0]                   out_byte;
  logic                         out_end;

  lmbs_pkg::store_ctl_t         store_ctl;
  logic [DATA_W-1:0]            rd_data;
  logic [DATA_W-1:0]            wr_data;
  logic                         store_ready;

  logic                         accept;
  logic                         is_scan;
  logic [1:0]                   r_val, g_val, b_val;
  logic [1:0]                   col_hi;
  logic [7:0]                   d_col;
  logic [ADDR_W-1:0]            d_addr;
  logic [PLANES-1:0][2:0]       new_bits;
  logic                         tail;
  logic                         col_last;
  logic                         in_data;
  logic [ADDR_W-1:0]            s_addr;
  logic [7:0]                   s_byte;
  logic                         s_end;
  logic [5:0]                   data_bits;
  logic                         out_free;
  logic                         out_load;

  assign cmd.ready = (state == S_IDLE) && store_ready;
  assign accept    = cmd.valid && cmd.ready;
  assign is_scan   = (cmd.func == lmbs_pkg::FUNC_SCAN);
  assign out_free  = !out_valid || stream.ready;
  assign out_load  = (state == S_BUSY) && !pend_draw && out_free;

  // draw: tile remap onto the 192-column strip
  always_comb begin
    r_val  = cmd.pixel_color[15:14];
    g_val  = cmd.pixel_color[10:9];
    b_val  = cmd.pixel_color[4:3];
    if (cmd.pixel_y[6]) begin
      col_hi = 2'b00;
    end else if (cmd.pixel_y[5]) begin
      col_hi = 2'b01;
    end else begin
      col_hi = 2'b10;
    end
    d_col  = {col_hi, cmd.pixel_x};
    d_addr = ADDR_W'({cmd.pixel_y[3:0], 7'b0}) + ADDR_W'({cmd.pixel_y[3:0], 6'b0})
           + ADDR_W'(d_col);
    for (int p = 0; p < PLANES; p++) begin
      new_bits[p] = {(b_val >> p) != 2'b0, (g_val >> p) != 2'b0, (r_val >> p) != 2'b0};
    end
  end

  // scan: byte kind and next position
  always_comb begin
    tail     = (scan_plane == PLANE_W'(PLANES));
    col_last = (scan_column == COL_W'(lmbs_pkg::ROW_BYTES - 1));
    in_data  = (scan_column < COL_W'(2 * lmbs_pkg::STRIP_COLS));
    s_addr   = ADDR_W'({scan_row, 7'b0}) + ADDR_W'({scan_row, 6'b0})
             + ADDR_W'(scan_column[COL_W-1:1]);
    s_end    = tail && col_last;
    if (tail) begin
      if (scan_column == COL_W'(lmbs_pkg::ROW_BYTES - 2)) begin
        s_byte = 8'd32;
      end else if (col_last) begin
        s_byte = 8'd160;
      end else begin
        s_byte = 8'd0;
      end
    end else if (!in_data) begin
      s_byte = ctrl_byte(scan_row, scan_column[2:0], style[0]);
    end else begin
      s_byte = 8'd0;
    end

    scan_plane_next  = scan_plane;
    scan_row_next    = scan_row;
    scan_column_next = scan_column + 1'b1;
    if (s_end) begin
      scan_plane_next  = '0;
      scan_row_next    = '0;
      scan_column_next = '0;
    end else if (col_last) begin
      scan_column_next = '0;
      if (scan_row == ROW_W'(ROWS - 1)) begin
        scan_row_next   = '0;
        scan_plane_next = scan_plane + 1'b1;
      end else begin
        scan_row_next = scan_row + 1'b1;
      end
    end
  end

  // modify the read word and pick the scanned plane
  always_comb begin
    wr_data   = rd_data;
    data_bits = '0;
    for (int p = 0; p < PLANES; p++) begin
      if (draw_hi) begin
        wr_data[p * lmbs_pkg::PLANE_BITS + 3 +: 3] = draw_bits[p];
      end else begin
        wr_data[p * lmbs_pkg::PLANE_BITS +: 3] = draw_bits[p];
      end
      if (scan_sel_plane == PLANE_W'(p)) begin
        data_bits = rd_data[p * lmbs_pkg::PLANE_BITS +: 6];
      end
    end
  end

  always_comb begin
    store_ctl.rd_en   = accept;
    store_ctl.rd_addr = is_scan ? s_addr : d_addr;
    store_ctl.wr_en   = (state == S_BUSY) && pend_draw && draw_en;
    store_ctl.wr_addr = draw_addr;
  end

  lmbs_store #(
    .PLANES (PLANES)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (store_ctl),
    .wr_data (wr_data),
    .rd_data (rd_data),
    .ready   (store_ready)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      style       <= '0;
      scan_plane  <= '0;
      scan_row    <= '0;
      scan_column <= '0;
      out_valid   <= 1'b0;
      pend_draw   <= 1'b0;
    end else begin
      if (cfg_we) begin
        style <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && stream.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state          <= S_BUSY;
            pend_draw      <= !is_scan;
            draw_en        <= (cmd.pixel_y < lmbs_pkg::Y_W'(96));
            draw_hi        <= cmd.pixel_y[4];
            draw_addr      <= d_addr;
            draw_bits      <= new_bits;
            scan_data_sel  <= !tail && in_data;
            scan_odd       <= scan_column[0];
            scan_sel_plane <= scan_plane;
            scan_byte      <= s_byte;
            scan_end       <= s_end;
            if (is_scan) begin
              scan_plane  <= scan_plane_next;
              scan_row    <= scan_row_next;
              scan_column <= scan_column_next;
            end
          end
        end
        S_BUSY: begin
          if (pend_draw) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_byte  <= scan_data_sel ? {1'b0, scan_odd, data_bits} : scan_byte;
            out_end   <= scan_end;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stream.valid     = out_valid;
  assign stream.out_byte  = out_byte;
  assign stream.frame_end = out_end;

`ifndef SYNTHESIS
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    !store_ready |-> !cmd.ready)
    else $error("request accepted during store clearing pass");

  a_scan_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_BUSY && !pend_draw && out_free) |=> out_valid)
    else $error("scan tick result not registered");

  a_frame_end_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_end) |-> (out_byte == 8'd160))
    else $error("frame end on a byte other than the tail control clock");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (scan_column < COL_W'(lmbs_pkg::ROW_BYTES)) && (scan_plane <= PLANE_W'(PLANES)))
    else $error("scan position out of range");
`endif

endmodule

`default_nettype wire
